### sv/sir_pkg.sv
// Package for the sparse index reshape block: field widths, codes and the
// control and status structs shared by the top level and the arithmetic unit.
// No dependencies.
package sir_pkg;

  localparam int KIND_W     = 2;
  localparam int POS_W      = 3;
  localparam int DIM_W      = 3;
  localparam int ROW_W      = 32;
  localparam int LIN_W      = 64;
  localparam int RANK_CFG_W = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CNT_W      = 6;

  localparam logic [KIND_W-1:0] KIND_IN_STRIDE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OUT_STRIDE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COORD      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_RANK  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_RANK = 4'd1;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } sir_op_t;

  typedef struct packed {
    logic    start;
    sir_op_t op;
  } sir_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sir_stat_t;

endpackage

### sv/sir_muldiv.sv
// Bit-serial multiply-accumulate and restoring divide around one shared
// 64-bit adder. Depends on sir_pkg.
module sir_muldiv import sir_pkg::*; #(
  parameter int COORD_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sir_ctl_t              ctl,
  input  logic [LIN_W-1:0]      opa,   // accumulator (mul) or dividend (div)
  input  logic [LIN_W-1:0]      opb,   // multiplicand (mul)
  input  logic [COORD_BITS-1:0] opc,   // multiplier (mul) or divisor (div)
  output sir_stat_t             stat,
  output logic [LIN_W-1:0]      res,
  output logic [COORD_BITS-1:0] rem
);

  sir_op_t               op_r, op_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [LIN_W-1:0]      acc_r, acc_nxt;
  logic [LIN_W-1:0]      mcand_r, mcand_nxt;
  logic [COORD_BITS-1:0] sel_r, sel_nxt;
  logic [COORD_BITS-1:0] rem_r, rem_nxt;

  logic [COORD_BITS:0]   trial;
  logic [LIN_W-1:0]      add_x, add_y;
  logic [LIN_W:0]        sum;
  logic                  carry;

  // Shared adder: add the partial product, or subtract the divisor from the
  // shifted remainder (carry out set means no borrow)
  assign trial = {rem_r, acc_r[LIN_W-1]};
  always_comb begin
    if (op_r == OP_MUL) begin
      add_x = acc_r;
      add_y = sel_r[0] ? mcand_r : '0;
    end else begin
      add_x = LIN_W'(trial);
      add_y = ~LIN_W'(sel_r);
    end
  end
  assign sum   = {1'b0, add_x} + {1'b0, add_y} + (LIN_W+1)'(op_r == OP_DIV);
  assign carry = sum[LIN_W];

  always_comb begin
    op_nxt    = op_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    sel_nxt   = sel_r;
    rem_nxt   = rem_r;
    if (ctl.start) begin
      op_nxt    = ctl.op;
      busy_nxt  = 1'b1;
      acc_nxt   = opa;
      mcand_nxt = opb;
      sel_nxt   = opc;
      rem_nxt   = '0;
      cnt_nxt   = (ctl.op == OP_MUL) ? CNT_W'(COORD_BITS - 1) : CNT_W'(LIN_W - 1);
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        acc_nxt   = sum[LIN_W-1:0];
        mcand_nxt = {mcand_r[LIN_W-2:0], 1'b0};
        sel_nxt   = sel_r >> 1;
      end else begin
        acc_nxt = {acc_r[LIN_W-2:0], carry};
        rem_nxt = carry ? sum[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    sel_r   <= sel_nxt;
    rem_r   <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = acc_r;
  assign rem       = rem_r;

endmodule

### sv/sparse_index_reshape_top.sv
// Top level of the sparse index reshape block: stride tables, sequencer and
// output register. Depends on sir_pkg and sir_muldiv.
//
// Remaps one sparse nonzero from an input tensor shape to an output shape.
// Stride items (tuser 0 for the input table, 1 for the output table) write
// one table entry as they are accepted. Coordinate items (tuser 2) arrive one per
// input dimension; each is multiplied by its input stride and added into a
// 64-bit linear index that wraps. The in_rank-th coordinate closes the
// nonzero: the block then emits out_rank items, one per output dimension in
// order, each the quotient of the running remainder by that dimension's
// stride, with tlast on the final one. A zero stride gives 0 and keeps the
// remainder. tuser 3 is dropped. One item is in work at a time and the input
// is not ready meanwhile. All arithmetic runs on one bit-serial unit with a
// single 64-bit adder; a zero stride dimension skips the divide, and each
// result item waits for the receiver. Rank registers act as 1 when written 0
// and as MAX_RANK when written above it; write them only while the block is
// idle.
module sparse_index_reshape_top import sir_pkg::*; #(
  parameter int MAX_RANK   = 8,
  parameter int COORD_BITS = 48
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input items
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [((POS_W+COORD_BITS+7)/8)*8-1:0] in_tdata,  // position, value, zero pad
  input  logic [KIND_W-1:0]         in_tuser,              // kind
  input  logic                      in_tlast,              // end_of_set
  // result items
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [((COORD_BITS+DIM_W+ROW_W+7)/8)*8-1:0] out_tdata, // out_coord, out_dim,
                                                                 // row_number, zero pad
  output logic                      out_tlast,             // last
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [RANK_CFG_W-1:0]     cfg_data
);

  localparam int IDX_W  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RANK_W = $clog2(MAX_RANK + 1);
  localparam int OUT_W  = ((COORD_BITS + DIM_W + ROW_W + 7) / 8) * 8;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_DLOAD = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  function automatic logic [RANK_W-1:0] eff_rank(input logic [RANK_CFG_W-1:0] r);
    logic [RANK_W-1:0] n;
    if (r == '0) begin
      n = RANK_W'(1);
    end else if (32'(r) > MAX_RANK) begin
      n = RANK_W'(MAX_RANK);
    end else begin
      n = RANK_W'(r);
    end
    return n;
  endfunction

  state_t                  state_r, state_nxt;
  logic [RANK_CFG_W-1:0]   in_rank_r, out_rank_r;
  logic [RANK_W-1:0]       coord_cnt_r, coord_cnt_nxt;
  logic [ROW_W-1:0]        row_cnt_r, row_cnt_nxt;
  logic [LIN_W-1:0]        lin_r, lin_nxt;
  logic [LIN_W-1:0]        rem_r, rem_nxt;
  logic [IDX_W-1:0]        dim_r, dim_nxt;
  logic [ROW_W-1:0]        row_num_r, row_num_nxt;
  logic [COORD_BITS-1:0]   coord_r, coord_nxt;
  logic                    eos_r;

  logic [COORD_BITS-1:0]   in_stride_r  [MAX_RANK];
  logic [COORD_BITS-1:0]   out_stride_r [MAX_RANK];

  logic [POS_W-1:0]        in_pos;
  logic [COORD_BITS-1:0]   in_value;
  logic                    in_acc;
  logic [RANK_W-1:0]       n_in, n_out;
  logic                    closes;
  logic                    last_dim;
  logic [COORD_BITS-1:0]   out_stride;

  sir_ctl_t                ctl;
  sir_stat_t               stat;
  logic [LIN_W-1:0]        unit_res;
  logic [COORD_BITS-1:0]   unit_rem;
  logic [LIN_W-1:0]        unit_opa;
  logic [LIN_W-1:0]        unit_opb;
  logic [COORD_BITS-1:0]   unit_opc;

  assign in_pos   = in_tdata[POS_W-1:0];
  assign in_value = in_tdata[POS_W +: COORD_BITS];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign n_in       = eff_rank(in_rank_r);
  assign n_out      = eff_rank(out_rank_r);
  // the coordinate in work is the last of its nonzero
  assign closes     = ((RANK_W+1)'(coord_cnt_r) + 1'b1) >= (RANK_W+1)'(n_in);
  assign last_dim   = ((RANK_W+1)'(dim_r) + 1'b1) == (RANK_W+1)'(n_out);
  assign out_stride = out_stride_r[dim_r];

  // Start a multiply on an accepted coordinate, a divide on a nonzero stride
  always_comb begin
    ctl.start = 1'b0;
    ctl.op    = OP_MUL;
    unit_opa  = lin_r;
    unit_opb  = LIN_W'(in_stride_r[coord_cnt_r[IDX_W-1:0]]);
    unit_opc  = in_value;
    if (in_acc && in_tuser == KIND_COORD) begin
      ctl.start = 1'b1;
    end else if (state_r == S_DLOAD && out_stride != '0) begin
      ctl.start = 1'b1;
      ctl.op    = OP_DIV;
      unit_opa  = rem_r;
      unit_opc  = out_stride;
    end
  end

  sir_muldiv #(
    .COORD_BITS (COORD_BITS)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .opa   (unit_opa),
    .opb   (unit_opb),
    .opc   (unit_opc),
    .stat  (stat),
    .res   (unit_res),
    .rem   (unit_rem)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    coord_cnt_nxt = coord_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    lin_nxt       = lin_r;
    rem_nxt       = rem_r;
    dim_nxt       = dim_r;
    row_num_nxt   = row_num_r;
    coord_nxt     = coord_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == KIND_COORD) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (stat.done) begin
          if (closes) begin
            // close the nonzero: divide down the finished index
            rem_nxt       = unit_res;
            lin_nxt       = '0;
            coord_cnt_nxt = '0;
            dim_nxt       = '0;
            row_num_nxt   = row_cnt_r;
            row_cnt_nxt   = eos_r ? '0 : row_cnt_r + 1'b1;
            state_nxt     = S_DLOAD;
          end else begin
            lin_nxt       = unit_res;
            coord_cnt_nxt = coord_cnt_r + 1'b1;
            if (eos_r) begin
              row_cnt_nxt = '0;
            end
            state_nxt     = S_IDLE;
          end
        end
      end
      S_DLOAD: begin
        if (out_stride == '0) begin
          coord_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.done) begin
          coord_nxt = unit_res[COORD_BITS-1:0];
          rem_nxt   = LIN_W'(unit_rem);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          if (last_dim) begin
            state_nxt = S_IDLE;
          end else begin
            dim_nxt   = dim_r + 1'b1;
            state_nxt = S_DLOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_rank_r   <= RANK_CFG_W'(1);
      out_rank_r  <= RANK_CFG_W'(1);
      coord_cnt_r <= '0;
      row_cnt_r   <= '0;
      lin_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      coord_cnt_r <= coord_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      lin_r       <= lin_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IN_RANK) begin
          in_rank_r <= cfg_data;
        end else if (cfg_index == CFG_OUT_RANK) begin
          out_rank_r <= cfg_data;
        end
      end
    end
  end

  // Payload: tables, remainder, output register
  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    dim_r     <= dim_nxt;
    row_num_r <= row_num_nxt;
    coord_r   <= coord_nxt;
    if (in_acc) begin
      eos_r <= in_tlast;
      if (32'(in_pos) < MAX_RANK) begin
        if (in_tuser == KIND_IN_STRIDE) begin
          in_stride_r[IDX_W'(in_pos)] <= in_value;
        end else if (in_tuser == KIND_OUT_STRIDE) begin
          out_stride_r[IDX_W'(in_pos)] <= in_value;
        end
      end
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = last_dim;
  assign out_tdata  = OUT_W'({row_num_r, DIM_W'(dim_r), coord_r});

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(coord_cnt_r) < MAX_RANK)
    else $error("coordinate count beyond the stride table");

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result item waits");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block not idle after the last result item");

  a_done_where: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (state_r == S_MUL || state_r == S_DIV))
    else $error("arithmetic unit finished outside a wait state");

endmodule

### tb/sparse_index_reshape_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sparse_index_reshape_top: loads stride tables,
// streams coordinate items in random bursts and checks every remapped
// coordinate against a predicting scoreboard. Depends on sir_pkg and the RTL.
module sparse_index_reshape_top_tb;
  import sir_pkg::*;

  localparam int MAX_RANK   = 8;
  localparam int COORD_BITS = 48;
  localparam int IN_DATA_W  = ((POS_W + COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((COORD_BITS + DIM_W + ROW_W + 7) / 8) * 8;

  // Kind 3 and register index 15 carry no meaning; the block must drop them
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 4'd15;

  localparam int PHASES        = 7;
  localparam int SETTLE_CYCLES = 200;    // well beyond one non-closing coordinate
  localparam int LONG_HOLD     = 1500;   // receiver back-pressure stretch
  localparam int STALL_LIMIT   = 20000;  // cycles with no item moving anywhere

  typedef logic [COORD_BITS-1:0] coord_t;
  localparam coord_t COORD_MAX = '1;

  typedef struct packed {
    coord_t           coord;
    logic [DIM_W-1:0] dim;
    logic [ROW_W-1:0] row;
    logic             last;
  } remapped_coord_t;

  // Predicts the remapped coordinates from the accepted items and holds
  // them until the block produces them.
  class coord_remap_scoreboard;
    coord_t                in_stride[MAX_RANK];
    coord_t                out_stride[MAX_RANK];
    logic [LIN_W-1:0]      lin_index;
    int unsigned           coord_cnt;
    logic [ROW_W-1:0]      row_cnt;
    logic [RANK_CFG_W-1:0] in_rank;
    logic [RANK_CFG_W-1:0] out_rank;
    remapped_coord_t       expected_coords[$];
    int unsigned           mismatches;

    function new();
      lin_index  = '0;
      coord_cnt  = 0;
      row_cnt    = '0;
      in_rank    = 1;
      out_rank   = 1;
      mismatches = 0;
    endfunction

    function int unsigned clamp_rank(logic [RANK_CFG_W-1:0] r);
      if (r == 0) return 1;
      if (r > MAX_RANK) return MAX_RANK;
      return r;
    endfunction

    function void write_rank(logic [CFG_IDX_W-1:0] idx, logic [RANK_CFG_W-1:0] val);
      if (idx == CFG_IN_RANK) in_rank = val;
      else if (idx == CFG_OUT_RANK) out_rank = val;
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos, coord_t val,
                            logic eos);
      int unsigned      slot;
      int unsigned      n_out;
      logic [LIN_W-1:0] rem;
      logic [LIN_W-1:0] quot;
      logic [LIN_W-1:0] div;
      remapped_coord_t  e;
      case (kind)
        KIND_IN_STRIDE:  in_stride[pos] = val;
        KIND_OUT_STRIDE: out_stride[pos] = val;
        KIND_COORD: begin
          slot = (coord_cnt >= MAX_RANK) ? MAX_RANK - 1 : coord_cnt;
          lin_index = lin_index + LIN_W'(val) * LIN_W'(in_stride[slot]);
          if (coord_cnt + 1 >= clamp_rank(in_rank)) begin
            n_out = clamp_rank(out_rank);
            rem   = lin_index;
            for (int d = 0; d < n_out; d++) begin
              div  = LIN_W'(out_stride[d]);
              quot = '0;
              if (div != 0) begin
                quot = rem / div;
                rem  = rem % div;
              end
              e.coord = quot[COORD_BITS-1:0];
              e.dim   = DIM_W'(d);
              e.row   = row_cnt;
              e.last  = (d + 1 == n_out);
              expected_coords.push_back(e);
            end
            row_cnt++;
            lin_index = '0;
            coord_cnt = 0;
          end else begin
            coord_cnt++;
          end
          if (eos) row_cnt = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_coord(remapped_coord_t got);
      remapped_coord_t want;
      if (expected_coords.size() == 0) begin
        $error("out_coord %0h (out_dim %0d) arrived with nothing expected", got.coord, got.dim);
        mismatches++;
        return;
      end
      want = expected_coords.pop_front();
      if (got.coord !== want.coord) begin
        $error("out_coord: expected %0h, got %0h", want.coord, got.coord);
        mismatches++;
      end
      if (got.dim !== want.dim) begin
        $error("out_dim: expected %0d, got %0d", want.dim, got.dim);
        mismatches++;
      end
      if (got.row !== want.row) begin
        $error("row_number: expected %0d, got %0d", want.row, got.row);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  // Every input of the block starts at a known value
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // position, value, zero pad
  logic [KIND_W-1:0]     in_tuser   = '0;  // kind
  logic                  in_tlast   = 1'b0; // end_of_set
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // out_coord, out_dim, row_number, zero pad
  logic                  out_tlast;        // last
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [RANK_CFG_W-1:0] cfg_data   = '0;

  coord_remap_scoreboard scoreboard = new();

  int unsigned burst_left   = 0;     // items left in the sender's current burst
  bit          hold_output  = 1'b0;  // asks the receiver for one long hold-off
  int unsigned quiet_cycles = 0;
  int unsigned in_dims[MAX_RANK];    // sizes behind the current input strides

  sparse_index_reshape_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Random 48-bit value biased towards the edges of the field
  function automatic coord_t pick_value();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return '0;
      1: return COORD_MAX;
      2: return coord_t'($urandom_range(0, 15));
      3: return coord_t'(1) << $urandom_range(0, COORD_BITS - 1);
      default: return wide[COORD_BITS-1:0];
    endcase
  endfunction

  // Offer one item at this edge, hold it until taken, then either carry on
  // with the burst (valid stays high) or drop valid for a random gap.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos, coord_t val,
                           logic eos);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_DATA_W'({val, pos});
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    scoreboard.note_item(kind, pos, val, eos);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  // Write one register; keep valid high when another write follows at once
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [RANK_CFG_W-1:0] val,
                           logic more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    scoreboard.write_rank(idx, val);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // Load row-major strides for n random dimension sizes, innermost first.
  // Now and then a stride is zeroed to exercise the zero-stride path.
  task automatic load_shape(logic [KIND_W-1:0] kind, int unsigned n);
    coord_t      stride;
    int unsigned dim;
    stride = 1;
    for (int k = n - 1; k >= 0; k--) begin
      dim = $urandom_range(1, 12);
      if (kind == KIND_IN_STRIDE) in_dims[k] = dim;
      send_item(kind, POS_W'(k), ($urandom_range(0, 9) == 0) ? '0 : stride, 1'($urandom));
      stride = stride * dim;
    end
  endtask

  // Stop offering, wait for every predicted coordinate, then let any
  // coordinate still in the arithmetic unit finish before touching registers.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (scoreboard.expected_coords.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: compare every accepted item with the oldest prediction
  always @(posedge clk) begin : result_monitor
    remapped_coord_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.coord = out_tdata[COORD_BITS-1:0];
      got.dim   = out_tdata[COORD_BITS +: DIM_W];
      got.row   = out_tdata[COORD_BITS + DIM_W +: ROW_W];
      got.last  = out_tlast;
      scoreboard.check_coord(got);
    end
  end

  // Receiver: stretches of random readiness, from fully ready to fully
  // stalled, plus one long hold-off on request so that the block backs up.
  // The hold-off counts from the first result item that waits.
  initial begin : receiver
    int unsigned span;
    int unsigned duty;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        out_tready <= 1'b0;
        while (!out_tvalid) @(posedge clk);
        repeat (LONG_HOLD) @(posedge clk);
      end
      span = $urandom_range(1, 60);
      duty = $urandom_range(0, 4);
      repeat (span) begin
        out_tready <= (duty == 4) ? 1'b1 : ($urandom_range(0, 3) < duty);
        @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no item moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sparse_index_reshape_top_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [RANK_CFG_W-1:0] in_ranks[PHASES];
    logic [RANK_CFG_W-1:0] out_ranks[PHASES];
    int unsigned           n_in;
    int unsigned           sent;
    int unsigned           target;
    coord_t                value;
    logic                  eos;

    // Rank settings per phase: reset value, full rank, and the out-of-range
    // codes 0 and 15 on both registers
    in_ranks  = '{4'd8, 4'd2, 4'd15, 4'd0, 4'd5, 4'd1, 4'd3};
    out_ranks = '{4'd8, 4'd15, 4'd0, 4'd3, 4'd1, 4'd8, 4'd6};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A write to an index with no register behind it must change nothing
    write_cfg(CFG_UNUSED, 4'b1010, 1'b0);

    // Directed part at the reset ranks of one input and one output dimension.
    // Fill every table entry first so that no unwritten entry is ever read.
    for (int k = 0; k < MAX_RANK; k++)
      send_item(KIND_IN_STRIDE, POS_W'(k), (k == 0) ? COORD_MAX : coord_t'(2 * k + 1), k[0]);
    for (int k = 0; k < MAX_RANK; k++)
      send_item(KIND_OUT_STRIDE, POS_W'(k),
                (k == 0) ? coord_t'(1) : (k == 1) ? coord_t'(0) :
                (k == 7) ? COORD_MAX : coord_t'(k + 2), k[0]);
    // Full-scale coordinate times full-scale stride wraps the 64-bit index
    // and gives a quotient wider than the output field
    send_item(KIND_COORD, '0, COORD_MAX, 1'b0);
    send_item(KIND_COORD, '1, '0, 1'b0);
    // Unused kind, all bits set, must neither count nor clear the row
    send_item(KIND_UNUSED, '1, COORD_MAX, 1'b1);
    // End of set on a closing coordinate restarts the row count
    send_item(KIND_COORD, '0, coord_t'(1), 1'b1);
    // Zero output stride: quotient zero, remainder kept
    send_item(KIND_OUT_STRIDE, '0, '0, 1'b0);
    send_item(KIND_COORD, '0, coord_t'(12345), 1'b0);
    send_item(KIND_OUT_STRIDE, '0, coord_t'(7), 1'b1);
    send_item(KIND_COORD, '0, pick_value(), 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_cfg(CFG_IN_RANK, in_ranks[p], 1'b1);
      write_cfg(CFG_OUT_RANK, out_ranks[p], 1'b0);
      n_in = scoreboard.clamp_rank(in_ranks[p]);

      // First phase: hold the receiver off while the sender keeps offering
      if (p == 0) hold_output = 1'b1;
      target = (p == 0) ? 32 : 0;

      load_shape(KIND_IN_STRIDE, n_in);
      load_shape(KIND_OUT_STRIDE, scoreboard.clamp_rank(out_ranks[p]));
      sent = n_in + scoreboard.clamp_rank(out_ranks[p]);

      // Mostly whole nonzeros with in-shape coordinates; some noise items
      // and stray stride rewrites in between
      do begin
        case ($urandom_range(0, 9))
          0: send_item(KIND_UNUSED, POS_W'($urandom), pick_value(), 1'($urandom));
          1: begin
            send_item($urandom_range(0, 1) ? KIND_OUT_STRIDE : KIND_IN_STRIDE,
                      POS_W'($urandom), pick_value(), 1'($urandom));
            sent++;
          end
          default: begin
            for (int c = 0; c < n_in; c++) begin
              value = ($urandom_range(0, 4) == 0) ? pick_value() :
                      coord_t'($urandom_range(0, in_dims[c] - 1));
              // end of set mostly on a closing coordinate, now and then mid-nonzero
              eos = ((c + 1 == n_in) && ($urandom_range(0, 4) == 0)) ||
                    ($urandom_range(0, 19) == 0);
              send_item(KIND_COORD, POS_W'($urandom), value, eos);
            end
            sent += n_in;
          end
        endcase
      end while (sent < target);

      // Leave a partial nonzero behind; the next phase may shrink the rank
      // under it, so that the next coordinate closes it
      repeat ($urandom_range(0, n_in - 1))
        send_item(KIND_COORD, POS_W'($urandom), pick_value(), 1'b0);
    end

    drain();
    if (scoreboard.mismatches == 0)
      $display("sparse_index_reshape_top_tb passed");
    else
      $display("sparse_index_reshape_top_tb failed");
    $finish;
  end

endmodule
